FILE: rtl/esdt_pkg.sv
// Shared widths, constants and month table for the epoch seconds to date/time converter.
package esdt_pkg;

  // Port widths
  localparam int IN_W    = 32;
  localparam int YEAR_W  = 11;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SECF_W  = 6;
  localparam int DOY_W   = 9;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 11'd1904;

  // Seconds to days: s / 86400 = (s >> 7) / 675, reciprocal of 675 scaled by 2^35
  localparam logic [25:0] DAY_RECIP   = 26'd50903316;
  localparam int          DAY_SHIFT   = 35;
  localparam logic [9:0]  DAY_ODD     = 10'd675;

  // Days to four-year cycles, reciprocal of 1461 scaled by 2^21
  localparam logic [10:0] CYC_RECIP      = 11'd1435;
  localparam int          CYC_SHIFT      = 21;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;

  // Second of day to hour, reciprocal of 3600 scaled by 2^22
  localparam logic [10:0] HOUR_RECIP    = 11'd1165;
  localparam int          HOUR_SHIFT    = 22;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

  // Second of hour to minute, reciprocal of 60 scaled by 2^17
  localparam logic [11:0] MIN_RECIP    = 12'd2184;
  localparam int          MIN_SHIFT    = 17;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;

  // Year lengths inside a four-year cycle
  localparam logic [8:0]  LEAP_DAYS   = 9'd366;
  localparam logic [8:0]  COMMON_DAYS = 9'd365;

  // First day of year of each month, index 12 is the year length
  function automatic logic [DOY_W-1:0] month_start(input logic leap, input logic [3:0] idx);
    logic [DOY_W-1:0] base;
    logic             adj;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      4'd12:   base = 9'd365;
      default: base = 9'd0;
    endcase
    // February 29 shifts every month after February by one day
    adj = leap && (idx >= 4'd2) && (idx <= 4'd12);
    return base + {8'd0, adj};
  endfunction

endpackage

FILE: rtl/esdt_month.sv
// Day of year to month and day of month lookup.
module esdt_month (
  input  logic [esdt_pkg::DOY_W-1:0]   doy,
  input  logic                         leap,
  output logic [esdt_pkg::MONTH_W-1:0] month,
  output logic [esdt_pkg::DAY_W-1:0]   day
);
  import esdt_pkg::*;

  logic [3:0]       mon_idx;
  logic [DOY_W-1:0] start;
  logic [DOY_W-1:0] day_full;

  // Count month starts at or below the day of year; the table rises, so this is the month index
  always_comb begin
    mon_idx = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy >= month_start(leap, 4'(i))) begin
        mon_idx = mon_idx + 4'd1;
      end
    end
  end

  assign start    = month_start(leap, mon_idx);
  assign day_full = doy - start + 9'd1;
  assign day      = day_full[DAY_W-1:0];
  assign month    = mon_idx + 4'd1;

endmodule

FILE: rtl/epoch_seconds_to_date_time_core.sv
// Top level: pipelined conversion of seconds since 1904-01-01 to calendar date and time.
//
// Accepts one count of seconds per cycle while not stalled and returns year, month, day,
// hour, minute and second from the output register. The nine register stages carry a
// valid bit each; every division by a constant is a reciprocal multiply in one stage,
// a multiply-back and subtract in the next and a single compare-and-correct step after.
// When the result is not taken, the whole pipeline holds and src_ready drops; in-flight
// items are kept, never dropped or repeated. Every 32-bit input maps to 1904..2040 with
// the simple every-fourth-year leap rule, and an exact year boundary starts the new year.
module epoch_seconds_to_date_time_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          src_valid,
  output logic                          src_ready,
  input  logic [esdt_pkg::IN_W-1:0]     seconds_since_epoch,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [esdt_pkg::YEAR_W-1:0]   year,
  output logic [esdt_pkg::MONTH_W-1:0]  month,
  output logic [esdt_pkg::DAY_W-1:0]    day,
  output logic [esdt_pkg::HOUR_W-1:0]   hour,
  output logic [esdt_pkg::MIN_W-1:0]    minute,
  output logic [esdt_pkg::SECF_W-1:0]   second
);
  import esdt_pkg::*;

  logic       adv;
  logic [9:1] vld;

  // Stage 1: reciprocal multiply for days
  logic [24:0] s1_q;
  logic [6:0]  s1_lo;
  logic [50:0] s1_prod;
  // Stage 2: day estimate and remainder
  logic [15:0] s2_est;
  logic [10:0] s2_rem;
  logic [6:0]  s2_lo;
  logic [24:0] s2_rem_full;
  logic [15:0] s2_est_next;
  // Stage 3: corrected days and second of day
  logic [15:0] s3_days;
  logic [16:0] s3_sod;
  logic [9:0]  s3_r_next;
  // Stage 4: reciprocal multiplies for cycle and hour
  logic [15:0] s4_days;
  logic [16:0] s4_sod;
  logic [26:0] s4_prod_c;
  logic [27:0] s4_prod_h;
  // Stage 5: estimates and remainders
  logic [5:0]  s5_cyc;
  logic [11:0] s5_crem;
  logic [4:0]  s5_hour;
  logic [12:0] s5_hrem;
  logic [5:0]  s5_cyc_next;
  logic [4:0]  s5_hour_next;
  logic [15:0] s5_crem_full;
  logic [16:0] s5_hrem_full;
  // Stage 6: corrected cycle, day of cycle, hour, second of hour
  logic [5:0]  s6_cyc;
  logic [10:0] s6_rem;
  logic [4:0]  s6_hour;
  logic [11:0] s6_msec;
  // Stage 7: year, day of year, minute multiply
  logic [YEAR_W-1:0] s7_year;
  logic [DOY_W-1:0]  s7_doy;
  logic              s7_leap;
  logic [4:0]        s7_hour;
  logic [11:0]       s7_msec;
  logic [23:0]       s7_prod_m;
  logic [1:0]        s7_yoff_next;
  logic [DOY_W-1:0]  s7_doy_next;
  logic [10:0]       s7_r;
  // Stage 8: month, day, minute estimate
  logic [YEAR_W-1:0]  s8_year;
  logic [MONTH_W-1:0] s8_month;
  logic [DAY_W-1:0]   s8_day;
  logic [4:0]         s8_hour;
  logic [5:0]         s8_min;
  logic [6:0]         s8_srem;
  logic [5:0]         s8_min_next;
  logic [11:0]        s8_srem_full;
  logic [MONTH_W-1:0] mon_month;
  logic [DAY_W-1:0]   mon_day;

  // Advance the whole pipeline unless a finished result is waiting
  assign adv       = res_ready | ~vld[9];
  assign src_ready = adv;
  assign res_valid = vld[9];

  // Shift valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[8:1], src_valid};
    end
  end

  // Stage 1: split off the power-of-two part of 86400, multiply by 1/675
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_q    <= seconds_since_epoch[31:7];
      s1_lo   <= seconds_since_epoch[6:0];
      s1_prod <= 51'(seconds_since_epoch[31:7]) * 51'(DAY_RECIP);
    end
  end

  // Stage 2: day estimate, low by at most one
  assign s2_est_next = s1_prod[50:DAY_SHIFT];
  assign s2_rem_full = s1_q - 25'(s2_est_next) * 25'(DAY_ODD);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_est <= s2_est_next;
      s2_rem <= s2_rem_full[10:0];
      s2_lo  <= s1_lo;
    end
  end

  // Stage 3: correct day count, rebuild second of day
  assign s3_r_next = (s2_rem >= 11'(DAY_ODD)) ? 10'(s2_rem - 11'(DAY_ODD)) : s2_rem[9:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_days <= (s2_rem >= 11'(DAY_ODD)) ? s2_est + 16'd1 : s2_est;
      s3_sod  <= {s3_r_next, s2_lo};
    end
  end

  // Stage 4: multiply by 1/1461 and 1/3600
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_days   <= s3_days;
      s4_sod    <= s3_sod;
      s4_prod_c <= 27'(s3_days) * 27'(CYC_RECIP);
      s4_prod_h <= 28'(s3_sod) * 28'(HOUR_RECIP);
    end
  end

  // Stage 5: cycle and hour estimates with remainders
  assign s5_cyc_next  = s4_prod_c[26:CYC_SHIFT];
  assign s5_hour_next = s4_prod_h[26:HOUR_SHIFT];
  assign s5_crem_full = s4_days - 16'(s5_cyc_next) * 16'(DAYS_PER_CYCLE);
  assign s5_hrem_full = s4_sod - 17'(s5_hour_next) * 17'(SECS_PER_HOUR);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_cyc  <= s5_cyc_next;
      s5_crem <= s5_crem_full[11:0];
      s5_hour <= s5_hour_next;
      s5_hrem <= s5_hrem_full[12:0];
    end
  end

  // Stage 6: correct cycle and hour
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s5_crem >= 12'(DAYS_PER_CYCLE)) begin
        s6_cyc <= s5_cyc + 6'd1;
        s6_rem <= 11'(s5_crem - 12'(DAYS_PER_CYCLE));
      end else begin
        s6_cyc <= s5_cyc;
        s6_rem <= s5_crem[10:0];
      end
      if (s5_hrem >= 13'(SECS_PER_HOUR)) begin
        s6_hour <= s5_hour + 5'd1;
        s6_msec <= 12'(s5_hrem - 13'(SECS_PER_HOUR));
      end else begin
        s6_hour <= s5_hour;
        s6_msec <= s5_hrem[11:0];
      end
    end
  end

  // Stage 7: year within the cycle; the leap year comes first
  assign s7_r = s6_rem - 11'(LEAP_DAYS);

  always_comb begin
    priority if (s6_rem < 11'(LEAP_DAYS)) begin
      s7_yoff_next = 2'd0;
      s7_doy_next  = s6_rem[8:0];
    end else if (s7_r >= 11'(2 * COMMON_DAYS)) begin
      s7_yoff_next = 2'd3;
      s7_doy_next  = 9'(s7_r - 11'(2 * COMMON_DAYS));
    end else if (s7_r >= 11'(COMMON_DAYS)) begin
      s7_yoff_next = 2'd2;
      s7_doy_next  = 9'(s7_r - 11'(COMMON_DAYS));
    end else begin
      s7_yoff_next = 2'd1;
      s7_doy_next  = s7_r[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_year   <= EPOCH_YEAR + 11'({s6_cyc, 2'b00}) + 11'(s7_yoff_next);
      s7_doy    <= s7_doy_next;
      s7_leap   <= (s6_rem < 11'(LEAP_DAYS));
      s7_hour   <= s6_hour;
      s7_msec   <= s6_msec;
      s7_prod_m <= 24'(s6_msec) * 24'(MIN_RECIP);
    end
  end

  // Stage 8: month and day lookup, minute estimate
  esdt_month u_month (
    .doy   (s7_doy),
    .leap  (s7_leap),
    .month (mon_month),
    .day   (mon_day)
  );

  assign s8_min_next  = s7_prod_m[22:MIN_SHIFT];
  assign s8_srem_full = s7_msec - 12'(s8_min_next) * 12'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_year  <= s7_year;
      s8_month <= mon_month;
      s8_day   <= mon_day;
      s8_hour  <= s7_hour;
      s8_min   <= s8_min_next;
      s8_srem  <= s8_srem_full[6:0];
    end
  end

  // Stage 9: correct minute, drive the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      year  <= s8_year;
      month <= s8_month;
      day   <= s8_day;
      hour  <= s8_hour;
      if (s8_srem >= 7'(SECS_PER_MIN)) begin
        minute <= s8_min + 6'd1;
        second <= 6'(s8_srem - 7'(SECS_PER_MIN));
      end else begin
        minute <= s8_min;
        second <= s8_srem[5:0];
      end
    end
  end

  // One correction step is enough for the day division
  a_day_rem: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (s3_sod < 17'd86400))
    else $error("second of day out of range");

  // Cycle and hour corrections leave in-range remainders
  a_cyc_rem: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (s6_rem < 11'(DAYS_PER_CYCLE)) && (s6_msec < SECS_PER_HOUR))
    else $error("cycle or hour remainder out of range");

  // Results fall inside calendar ranges
  a_calendar: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (hour <= 5'd23)
                  && (minute <= 6'd59) && (second <= 6'd59))
    else $error("result field out of range");

  // A transfer in shows up in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_ready |=> vld[1])
    else $error("accepted item lost at entry");

  // A stalled result holds its valid bit and those of the stages behind it
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule

FILE: test/tb.sv
// Testbench for the epoch seconds to calendar date and time converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esdt_pkg::*;

  localparam int unsigned SECS_IN_DAY   = 86400;
  localparam int unsigned DAYS_IN_CYCLE = 1461;
  localparam int unsigned FIRST_YEAR    = 1904;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned TAIL_CYCLES   = 30;

  // First day of year of each month in a common year, index 12 is the year length
  localparam int unsigned MONTH_START[13] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

  typedef struct {
    logic [IN_W-1:0]    secs;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SECF_W-1:0]  second;
  } date_time_t;

  // First day of month m (0..12) inside a year, leap years shifted after February
  function automatic int unsigned month_first_day(input bit leap, input int unsigned m);
    return MONTH_START[m] + ((leap && m >= 2) ? 1 : 0);
  endfunction

  // Day count from the epoch to January 1 of year offset yoff in four-year cycle cyc
  function automatic int unsigned year_start_days(input int unsigned cyc,
                                                  input int unsigned yoff);
    return DAYS_IN_CYCLE * cyc + ((yoff == 0) ? 0 : 366 + 365 * (yoff - 1));
  endfunction

  class DateTimeBoard;
    date_time_t pending_dates[$];
    int unsigned errors = 0;

    function automatic date_time_t predict_date_time(input logic [IN_W-1:0] secs);
      int unsigned s, days, sod, cyc, rem, yoff, doy, m;
      bit leap;
      date_time_t r;
      s    = secs;
      days = s / SECS_IN_DAY;
      sod  = s % SECS_IN_DAY;
      cyc  = days / DAYS_IN_CYCLE;
      rem  = days % DAYS_IN_CYCLE;
      // First year of each cycle is the leap year
      if (rem < 366) begin
        yoff = 0;
        doy  = rem;
        leap = 1'b1;
      end else begin
        yoff = 1 + (rem - 366) / 365;
        doy  = (rem - 366) % 365;
        leap = 1'b0;
      end
      m = 0;
      while (m < 11 && doy >= month_first_day(leap, m + 1))
        m++;
      r.secs   = secs;
      r.year   = YEAR_W'(FIRST_YEAR + 4 * cyc + yoff);
      r.month  = MONTH_W'(m + 1);
      r.day    = DAY_W'(doy - month_first_day(leap, m) + 1);
      r.hour   = HOUR_W'(sod / 3600);
      r.minute = MIN_W'((sod % 3600) / 60);
      r.second = SECF_W'(sod % 60);
      return r;
    endfunction

    function void note_seconds(input logic [IN_W-1:0] secs);
      pending_dates.push_back(predict_date_time(secs));
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(input date_time_t got);
      date_time_t exp_dt;
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with none pending",
                                  got.year, got.month, got.day,
                                  got.hour, got.minute, got.second));
        return;
      end
      exp_dt = pending_dates.pop_front();
      if (got.year !== exp_dt.year)
        report_mismatch($sformatf("year got %0d want %0d for %0d",
                                  got.year, exp_dt.year, exp_dt.secs));
      if (got.month !== exp_dt.month)
        report_mismatch($sformatf("month got %0d want %0d for %0d",
                                  got.month, exp_dt.month, exp_dt.secs));
      if (got.day !== exp_dt.day)
        report_mismatch($sformatf("day got %0d want %0d for %0d",
                                  got.day, exp_dt.day, exp_dt.secs));
      if (got.hour !== exp_dt.hour)
        report_mismatch($sformatf("hour got %0d want %0d for %0d",
                                  got.hour, exp_dt.hour, exp_dt.secs));
      if (got.minute !== exp_dt.minute)
        report_mismatch($sformatf("minute got %0d want %0d for %0d",
                                  got.minute, exp_dt.minute, exp_dt.secs));
      if (got.second !== exp_dt.second)
        report_mismatch($sformatf("second got %0d want %0d for %0d",
                                  got.second, exp_dt.second, exp_dt.secs));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               src_valid = 1'b0;
  logic               src_ready;
  logic [IN_W-1:0]    seconds_since_epoch = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SECF_W-1:0]  second;

  bit          calm = 1'b0;
  int unsigned cycles = 0;
  DateTimeBoard board = new();

  epoch_seconds_to_date_time_core dut (
    .clk                 (clk),
    .rst                 (rst),
    .src_valid           (src_valid),
    .src_ready           (src_ready),
    .seconds_since_epoch (seconds_since_epoch),
    .res_valid           (res_valid),
    .res_ready           (res_ready),
    .year                (year),
    .month               (month),
    .day                 (day),
    .hour                (hour),
    .minute              (minute),
    .second              (second)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Stall the result side at random, except in the calm stretch
  always @(posedge clk) begin
    res_ready <= calm || ($urandom_range(0, 99) >= 21);
  end

  // Check each result transfer; inputs are stable from the falling edge on
  always @(negedge clk) begin
    date_time_t got;
    if (!rst && res_valid && res_ready) begin
      got.secs   = '0;
      got.year   = year;
      got.month  = month;
      got.day    = day;
      got.hour   = hour;
      got.minute = minute;
      got.second = second;
      board.check_result(got);
    end
  end

  // Present one count and hold it until the transfer
  task automatic send_seconds(input logic [IN_W-1:0] secs);
    bit taken;
    // Idle at random first, each further idle step with a chance of 21 in a hundred
    while (!calm && $urandom_range(0, 99) < 21) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid           <= 1'b1;
    seconds_since_epoch <= secs;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = src_ready;
      @(posedge clk);
    end
    board.note_seconds(secs);
  endtask

  // Pick a count near a day, month or year boundary, or fully random
  function automatic logic [IN_W-1:0] pick_seconds();
    longint unsigned days, s;
    int unsigned cyc, yoff, m, sod;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: begin
        days = $urandom_range(0, 49710);
        case ($urandom_range(0, 2))
          0: sod = 0;
          1: sod = SECS_IN_DAY - 1;
          default: sod = $urandom_range(0, SECS_IN_DAY - 1);
        endcase
      end
      default: begin
        cyc  = $urandom_range(0, 34);
        yoff = $urandom_range(0, 3);
        m    = $urandom_range(0, 11);
        days = year_start_days(cyc, yoff) + month_first_day(yoff == 0, m);
        days = days + $urandom_range(0, 2);
        days = (days == 0) ? 0 : days - 1;
        case ($urandom_range(0, 2))
          0: sod = 0;
          1: sod = SECS_IN_DAY - 1;
          default: sod = $urandom_range(0, SECS_IN_DAY - 1);
        endcase
      end
    endcase
    s = days * SECS_IN_DAY + sod;
    if (s > 64'hFFFF_FFFF)
      return $urandom();
    return IN_W'(s);
  endfunction

  initial begin
    logic [IN_W-1:0] directed[$];
    int unsigned n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, time-of-day rollovers, leap day and year boundaries
    directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
                 32'd86399, 32'd86400, 59 * SECS_IN_DAY, 60 * SECS_IN_DAY,
                 365 * SECS_IN_DAY, 366 * SECS_IN_DAY - 1, 366 * SECS_IN_DAY,
                 (366 + 59) * SECS_IN_DAY,
                 year_start_days(0, 2) * SECS_IN_DAY,
                 year_start_days(0, 3) * SECS_IN_DAY,
                 year_start_days(1, 0) * SECS_IN_DAY - 1,
                 year_start_days(1, 0) * SECS_IN_DAY,
                 year_start_days(34, 0) * SECS_IN_DAY,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (directed[i])
      send_seconds(directed[i]);

    // Random part with a stretch of back-to-back transfers in the middle
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 150 && n < 300);
      send_seconds(pick_seconds());
    end
    src_valid <= 1'b0;
    calm      <= 1'b0;

    // Drain, then watch for stray results
    while (board.pending_dates.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.pending_dates.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
